// ----- hdl/dq_pkg.sv -----
// dq_pkg: shared types and constants for the double-ended queue.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package dq_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 7;
    localparam int CNT_W     = 7;
    localparam int DEPTH     = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 2'd0,
        FN_PUSH_FRONT = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } state_t;

    typedef struct packed {
        logic issue;
        logic respond;
    } dq_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/array_double_ended_queue.sv -----
// array_double_ended_queue: top level, joins dq_ctrl and dq_datapath.
// Depends on dq_pkg, dq_ctrl, dq_datapath.
//
//  channel   handshake        word
//  op in     start / busy     func, push_value
//  result    done (strobe)    pop_value, status, occupancy
//  config    cfg_we           cfg_data (capacity)
//
// A word is accepted in S_IDLE and answered in S_RESP, while the entry
// memory's registered read returns the popped value. busy is high in the
// result cycle. Reset (rst_n, async) empties the queue and sets capacity to 64;
// no clearing pass. The result cannot be stalled.
`default_nettype none
module array_double_ended_queue
    import dq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [FUNC_W-1:0]        func,
    input  wire logic signed [DATA_W-1:0] push_value,
    output logic                          done,
    output logic signed [DATA_W-1:0]      pop_value,
    output logic [STAT_W-1:0]             status,
    output logic [CNT_W-1:0]              occupancy,
    input  wire logic                     cfg_we,
    input  wire logic [CAP_W-1:0]         cfg_data
);

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .push_value (push_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule
`default_nettype wire

// ----- hdl/dq_ctrl.sv -----
// dq_ctrl: controller FSM; accepts a word and sequences the response cycle.
// Depends on dq_pkg.
`default_nettype none
module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output dq_cmd_t      cmd,
    output logic         busy,
    output logic         done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.issue   = 1'b0;
        cmd.respond = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                busy        = 1'b1;
                done        = 1'b1;
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/dq_datapath.sv -----
// dq_datapath: entry memory, head pointer, count, capacity and result registers.
// Depends on dq_pkg; driven by dq_ctrl commands.
`default_nettype none
module dq_datapath
    import dq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dq_cmd_t                  cmd,
    input  wire logic [FUNC_W-1:0]        func,
    input  wire logic signed [DATA_W-1:0] push_value,
    input  wire logic                     cfg_we,
    input  wire logic [CAP_W-1:0]         cfg_data,
    output logic signed [DATA_W-1:0]      pop_value,
    output logic [STAT_W-1:0]             status,
    output logic [CNT_W-1:0]              occupancy
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int CMP_W  = (SUM_W > CAP_W) ? SUM_W : CAP_W;

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  capacity_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [SUM_W-1:0]  head_ext, count_ext, sum_back, sum_last;
    logic [ADDR_W-1:0] back_addr, last_addr, head_inc, head_dec;
    logic [CMP_W-1:0]  cap_ext, limit, count_cmp;
    logic              full, empty;
    func_t             fn;

    assign head_ext  = SUM_W'(head_reg);
    assign count_ext = SUM_W'(count_reg);
    assign sum_back  = head_ext + count_ext;
    assign sum_last  = head_ext + count_ext - SUM_W'(1);

    // circular wrap: sums stay below twice the depth
    assign back_addr = (sum_back >= SUM_W'(DEPTH)) ? ADDR_W'(sum_back - SUM_W'(DEPTH))
                                                   : ADDR_W'(sum_back);
    assign last_addr = (sum_last >= SUM_W'(DEPTH)) ? ADDR_W'(sum_last - SUM_W'(DEPTH))
                                                   : ADDR_W'(sum_last);
    assign head_inc  = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign head_dec  = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);

    assign cap_ext   = CMP_W'(capacity_reg);
    assign limit     = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign count_cmp = CMP_W'(count_reg);
    assign full      = (count_cmp >= limit);
    assign empty     = (count_reg == '0);
    assign fn        = func_t'(func);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_addr;
        rd_addr     = head_reg;
        if (cmd.issue)
        begin
            status_next = ST_OK;
            pop_ok_next = 1'b0;
            case (fn)
                FN_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_addr;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = head_reg;
                        head_next   = head_inc;
                        count_next  = count_reg - CNT_W'(1);
                        pop_ok_next = 1'b1;
                    end
                end
                FN_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = last_addr;
                        count_next  = count_reg - CNT_W'(1);
                        pop_ok_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= ST_OK;
            pop_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign pop_value = (cmd.respond && pop_ok_reg) ? rd_data_reg : '0;
    assign status    = status_reg;
    assign occupancy = count_reg;

endmodule
`default_nettype wire

// ----- hdl/dq_checker.sv -----
// dq_checker: port-level assertions for array_double_ended_queue, with bind.
// Depends on dq_pkg and array_double_ended_queue.
`default_nettype none
module dq_checker
    import dq_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic signed [DATA_W-1:0] pop_value,
    input wire logic [STAT_W-1:0]        status,
    input wire logic [CNT_W-1:0]         occupancy
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted word gave no result next cycle");

    a_no_result_unasked: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start) && !$past(busy))
        else $error("result without an accepted word");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL || status == ST_EMPTY) |-> pop_value == '0)
        else $error("failed operation returned data");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty status with entries held");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |=> !done)
        else $error("back-to-back results");

endmodule

bind array_double_ended_queue dq_checker u_dq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
);
`default_nettype wire

// ----- verif/array_double_ended_queue_tb.sv -----
// array_double_ended_queue_tb: self-checking bench for the bounded deque.
// Depends on dq_pkg and array_double_ended_queue; mirrors the deque's state
// to predict each result word and checks it as the done strobe comes back.
`timescale 1ns / 100ps
module array_double_ended_queue_tb;
    import dq_pkg::*;

    localparam int IDLE_LIMIT = 500;

    typedef struct packed {
        func_t                     op;
        logic signed [DATA_W-1:0]  value;
    } deque_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pop_value;
        status_t                   st;
        logic [CNT_W-1:0]          occ;
    } deque_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;
    logic                     done;
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         occupancy;
    logic                     cfg_we;
    logic [CAP_W-1:0]         cfg_data;

    deque_word_t   pending_words[$];
    deque_result_t expected_results[$];

    // mirrored deque state
    logic [DATA_W-1:0] ring_store [DEPTH];
    logic [5:0]        ring_head;
    logic [CNT_W-1:0]  ring_count;
    logic [CAP_W-1:0]  ring_cap;

    int error_count;
    int gap_left;
    int burst_left;
    int idle_cycles;

    array_double_ended_queue uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .push_value (push_value),
        .done       (done),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic deque_apply(input func_t op, input logic signed [DATA_W-1:0] v,
                               output deque_result_t r);
        logic [CAP_W-1:0] lim;
        logic [5:0]       idx;
        lim = (ring_cap > DEPTH) ? CAP_W'(DEPTH) : ring_cap;
        r.pop_value = '0;
        r.st        = ST_OK;
        case (op)
            FN_PUSH_BACK, FN_PUSH_FRONT:
            begin
                if (ring_count >= lim)
                    r.st = ST_FULL;
                else if (op == FN_PUSH_BACK)
                begin
                    idx = ring_head + ring_count[5:0];
                    ring_store[idx] = v;
                    ring_count++;
                end
                else
                begin
                    ring_head = ring_head - 6'd1;
                    ring_store[ring_head] = v;
                    ring_count++;
                end
            end
            default:
            begin
                if (ring_count == 0)
                    r.st = ST_EMPTY;
                else if (op == FN_POP_FRONT)
                begin
                    r.pop_value = ring_store[ring_head];
                    ring_head = ring_head + 6'd1;
                    ring_count--;
                end
                else
                begin
                    idx = ring_head + ring_count[5:0] - 6'd1;
                    r.pop_value = ring_store[idx];
                    ring_count--;
                end
            end
        endcase
        r.occ = ring_count;
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk)
    begin : driver
        logic          nxt_start;
        deque_word_t   w;
        deque_result_t r;
        if (rst_n)
        begin
            nxt_start = start;
            if (start && !busy)
            begin
                deque_apply(func_t'(func), push_value, r);
                expected_results.push_back(r);
                nxt_start = 1'b0;
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push_value <= $urandom;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    func       <= w.op;
                    push_value <= w.value;
                    nxt_start  = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            start <= nxt_start;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        deque_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (pop_value !== e.pop_value)
                begin
                    $error("pop_value: expected %0d, actual %0d", e.pop_value, pop_value);
                    error_count++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, actual %0d", e.st, status);
                    error_count++;
                end
                if (occupancy !== e.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", e.occ, occupancy);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_word(input func_t op, input logic signed [DATA_W-1:0] v);
        deque_word_t w;
        w.op    = op;
        w.value = v;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || start || expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        ring_cap = v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic add_random(input int n);
        int   seg;
        int   bias;
        logic [DATA_W-1:0] v;
        while (n > 0)
        begin
            seg = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0: bias = 100;
                1: bias = 90;
                2: bias = 10;
                3: bias = 0;
                default: bias = 50;
            endcase
            for (int i = 0; i < seg && n > 0; i++)
            begin
                v = $urandom;
                if ($urandom_range(0, 15) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = '0;
                        default: v = '1;
                    endcase
                end
                if ($urandom_range(0, 99) < bias)
                    add_word($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, v);
                else
                    add_word($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT, v);
                n--;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [CAP_W-1:0] caps [10];
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FN_PUSH_BACK;
        push_value  = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        gap_left    = 0;
        burst_left  = 4;
        idle_cycles = 0;
        ring_head   = '0;
        ring_count  = '0;
        ring_cap    = CAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty pops, extreme values, both ends
        add_word(FN_POP_FRONT, 32'sd5);
        add_word(FN_POP_BACK, -32'sd1);
        add_word(FN_PUSH_BACK, 32'h7FFF_FFFF);
        add_word(FN_PUSH_FRONT, 32'h8000_0000);
        add_word(FN_PUSH_BACK, -32'sd1);
        add_word(FN_PUSH_FRONT, 32'sd0);
        add_word(FN_POP_FRONT, 32'sd0);
        add_word(FN_POP_BACK, 32'sd0);
        add_word(FN_POP_BACK, 32'sd0);
        add_word(FN_POP_FRONT, 32'sd0);
        add_word(FN_POP_FRONT, 32'sd0);

        // single entry, then full
        set_capacity(7'd1);
        add_word(FN_PUSH_BACK, 32'h5555_AAAA);
        add_word(FN_PUSH_FRONT, 32'h1234_5678);
        add_word(FN_POP_BACK, 32'sd0);
        add_word(FN_POP_BACK, 32'sd0);

        // zero capacity
        set_capacity(7'd0);
        add_word(FN_PUSH_BACK, 32'sd7);
        add_word(FN_PUSH_FRONT, 32'sd7);
        add_word(FN_POP_FRONT, 32'sd0);

        // capacity lowered below the count
        set_capacity(7'd127);
        for (int i = 0; i < 5; i++)
            add_word(FN_PUSH_BACK, $urandom);
        set_capacity(7'd2);
        add_word(FN_PUSH_FRONT, 32'sd9);
        add_word(FN_POP_FRONT, 32'sd0);
        add_word(FN_POP_BACK, 32'sd0);
        add_word(FN_POP_FRONT, 32'sd0);
        add_word(FN_PUSH_BACK, 32'sd3);

        caps = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd63,
                 7'($urandom_range(3, 62)), 7'd65, 7'($urandom_range(1, 127)), 7'd64};
        foreach (caps[i])
        begin
            set_capacity(caps[i]);
            add_random(120);
        end

        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/array_double_ended_queue.sv
hdl/dq_checker.sv
verif/array_double_ended_queue_tb.sv
